FILE: sv/cme_pkg.sv
// Shared types, constants and score function for the clock offset median estimator.
package cme_pkg;

  localparam int WINDOW_SIZE = 8;
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
  localparam int IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

  localparam int TS_W   = 63;
  localparam int OFS_W  = 64;
  localparam int RTT_W  = 32;
  localparam int QUAL_W = 7;

  localparam logic [RTT_W-1:0]  MAX_RTT_RESET = 32'd100000;
  localparam logic [RTT_W-1:0]  RTT_FAST_US   = 32'd5000;
  localparam logic [RTT_W-1:0]  RTT_SLOW_US   = 32'd20000;
  localparam logic [QUAL_W-1:0] SCORE_FAST    = 7'd100;
  localparam logic [QUAL_W-1:0] SCORE_MID     = 7'd50;
  localparam logic [QUAL_W-1:0] SCORE_SLOW    = 7'd10;
  localparam int                SYNC_MIN      = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SUMS,
    ST_JUDGE,
    ST_LOAD,
    ST_RANK,
    ST_SEL,
    ST_EMIT
  } cme_state_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic rank;
  } cell_ctl_t;

  typedef struct packed {
    logic [OFS_W-1:0] value;
    logic [IDX_W-1:0] idx;
  } probe_t;

  // Sample-count score: held * 100 / WINDOW_SIZE, truncated.
  function automatic logic [QUAL_W-1:0] count_score(input logic [CNT_W-1:0] held);
    logic [CNT_W+6:0] prod;
    prod = (CNT_W + 7)'(held) * (CNT_W + 7)'(SCORE_FAST);
    return QUAL_W'(prod / WINDOW_SIZE);
  endfunction

endpackage

FILE: sv/cme_front.sv
// Timestamp difference pipeline: round trip, offset sum and timestamp validity.
module cme_front
  import cme_pkg::*;
(
  input  logic             clk,
  input  logic [TS_W-1:0]  t1,
  input  logic [TS_W-1:0]  t2,
  input  logic [TS_W-1:0]  t3,
  input  logic [TS_W-1:0]  t4,
  output logic [OFS_W-1:0] rtt,
  output logic [OFS_W-1:0] sum,
  output logic             ts_ok
);

  logic [OFS_W-1:0] d41_r, d32_r, d21_r, d34_r;
  logic             ok1_r;
  logic [OFS_W-1:0] rtt_r, sum_r;
  logic             ok2_r;

  // Both stages run every cycle; the inputs are held stable while an item is in work.
  always_ff @(posedge clk) begin
    d41_r <= {1'b0, t4} - {1'b0, t1};
    d32_r <= {1'b0, t3} - {1'b0, t2};
    d21_r <= {1'b0, t2} - {1'b0, t1};
    d34_r <= {1'b0, t3} - {1'b0, t4};
    ok1_r <= (t1 != '0) && (t2 != '0) && (t3 != '0);
    rtt_r <= d41_r - d32_r;
    sum_r <= d21_r + d34_r;
    ok2_r <= ok1_r;
  end

  assign rtt   = rtt_r;
  assign sum   = sum_r;
  assign ts_ok = ok2_r;

endmodule

FILE: sv/cme_cell.sv
// One cell of the sample row: holds a sample, passes a probe on and counts its rank.
module cme_cell
  import cme_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [CNT_W-1:0] held,
  input  logic [OFS_W-1:0] shift_in,
  input  probe_t           probe_in,
  output logic [OFS_W-1:0] value_out,
  output probe_t           probe_out,
  output logic [CNT_W-1:0] rank_out
);

  logic [OFS_W-1:0] value_r;
  probe_t           probe_r;
  logic [CNT_W-1:0] rank_r;
  logic [CNT_W-1:0] rank_nxt;
  logic             own_valid;
  logic             probe_valid;
  logic             probe_below;

  assign own_valid   = CNT_W'(cell_idx) < held;
  assign probe_valid = CNT_W'(probe_r.idx) < held;

  // Ties are broken by slot index so that every held sample gets a distinct rank.
  assign probe_below = ($signed(probe_r.value) < $signed(value_r)) ||
                       ((probe_r.value == value_r) && (probe_r.idx < cell_idx));

  always_comb begin
    rank_nxt = rank_r;
    if (own_valid && probe_valid && probe_below) begin
      rank_nxt = rank_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value_r <= shift_in;
    end
    if (ctl.load) begin
      probe_r.value <= value_r;
      probe_r.idx   <= cell_idx;
      rank_r        <= '0;
    end else if (ctl.rank) begin
      probe_r <= probe_in;
      rank_r  <= rank_nxt;
    end
  end

  assign value_out = value_r;
  assign probe_out = probe_r;
  assign rank_out  = rank_r;

endmodule

FILE: sv/clock_offset_median_estimator.sv
// Top level of the clock offset estimator with a median filter over recent samples.
// One exchange is taken at a time. A rejected exchange passes the difference, sum, judge
// and emit states after the request is accepted; an accepted one also passes the load,
// rank and select states; in the ranking pass every stored offset travels once around the
// row of sample cells while each cell counts the samples below its own. The next request
// is taken as soon as the result sits in the output register, even while that result is
// still stalled. The newest offset enters the first cell and the oldest drops out of the
// last, so the row always holds the most recent samples.
module clock_offset_median_estimator
  import cme_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TS_W-1:0]    in_master_send_time,
  input  logic [TS_W-1:0]    in_slave_receive_time,
  input  logic [TS_W-1:0]    in_slave_send_time,
  input  logic [TS_W-1:0]    in_master_receive_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic [OFS_W-1:0]   out_filtered_offset,
  output logic [RTT_W-1:0]   out_last_round_trip,
  output logic [QUAL_W-1:0]  out_sync_quality,
  output logic               out_synced,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RTT_W-1:0]   cfg_max_round_trip_us
);

  cme_state_t       state_r, state_nxt;
  cell_ctl_t        ctl;

  logic [TS_W-1:0]  t1_r, t2_r, t3_r, t4_r;
  logic [RTT_W-1:0] max_rtt_r;

  logic [OFS_W-1:0] rtt, sum;
  logic             ts_ok;
  logic             pass;
  logic [OFS_W-1:0] half;

  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  rank_cnt_r;
  logic [OFS_W-1:0]  cur_offset_r;
  logic [RTT_W-1:0]  cur_rtt_r;
  logic [QUAL_W-1:0] cur_quality_r;
  logic              cur_sync_r;
  logic              accepted_r;
  logic [QUAL_W-1:0] rtt_score;
  logic [QUAL_W:0]   score_sum;
  logic [OFS_W-1:0]  median;

  logic              out_valid_r;
  logic              out_accepted_r;
  logic [OFS_W-1:0]  out_offset_r;
  logic [RTT_W-1:0]  out_rtt_r;
  logic [QUAL_W-1:0] out_quality_r;
  logic              out_synced_r;
  logic              out_free;
  logic              in_take;

  logic [OFS_W-1:0]  cell_value [WINDOW_SIZE];
  probe_t            cell_probe [WINDOW_SIZE];
  logic [CNT_W-1:0]  cell_rank  [WINDOW_SIZE];

  assign out_free = !out_valid_r || !out_stall;
  assign in_take  = in_valid && !in_stall;

  // Configuration register; always ready.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rtt_r <= MAX_RTT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_rtt_r <= cfg_max_round_trip_us;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      t1_r <= in_master_send_time;
      t2_r <= in_slave_receive_time;
      t3_r <= in_slave_send_time;
      t4_r <= in_master_receive_time;
    end
  end

  cme_front u_front (
    .clk   (clk),
    .t1    (t1_r),
    .t2    (t2_r),
    .t3    (t3_r),
    .t4    (t4_r),
    .rtt   (rtt),
    .sum   (sum),
    .ts_ok (ts_ok)
  );

  assign pass = ts_ok && !rtt[OFS_W-1] && (rtt[OFS_W-1:RTT_W] == '0) &&
                (rtt[RTT_W-1:0] <= max_rtt_r);

  // Halving toward zero: add one to a negative sum before the arithmetic shift.
  assign half = OFS_W'($signed(sum + OFS_W'(sum[OFS_W-1])) >>> 1);

  assign held_nxt = (held_r != CNT_W'(WINDOW_SIZE)) ? held_r + CNT_W'(1) : held_r;

  always_comb begin
    if (rtt[RTT_W-1:0] < RTT_FAST_US) begin
      rtt_score = SCORE_FAST;
    end else if (rtt[RTT_W-1:0] < RTT_SLOW_US) begin
      rtt_score = SCORE_MID;
    end else begin
      rtt_score = SCORE_SLOW;
    end
    score_sum = {1'b0, count_score(held_nxt)} + {1'b0, rtt_score};
  end

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_SIZE; gi++) begin : g_cell
      cme_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .cell_idx  (IDX_W'(gi)),
        .held      (held_r),
        .shift_in  ((gi == 0) ? half : cell_value[(gi + WINDOW_SIZE - 1) % WINDOW_SIZE]),
        .probe_in  (cell_probe[(gi + WINDOW_SIZE - 1) % WINDOW_SIZE]),
        .value_out (cell_value[gi]),
        .probe_out (cell_probe[gi]),
        .rank_out  (cell_rank[gi])
      );
    end
  endgenerate

  // The upper median is the held sample whose rank equals held / 2.
  always_comb begin
    median = cur_offset_r;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if ((CNT_W'(i) < held_r) && (cell_rank[i] == (held_r >> 1))) begin
        median = cell_value[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        state_nxt = ST_SUMS;
      end
      ST_SUMS: begin
        state_nxt = ST_JUDGE;
      end
      ST_JUDGE: begin
        if (pass) begin
          ctl.shift = 1'b1;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_LOAD: begin
        ctl.load  = 1'b1;
        state_nxt = ST_RANK;
      end
      ST_RANK: begin
        ctl.rank = 1'b1;
        if (rank_cnt_r == CNT_W'(WINDOW_SIZE - 1)) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r        <= '0;
      cur_offset_r  <= '0;
      cur_rtt_r     <= '0;
      cur_quality_r <= '0;
      cur_sync_r    <= 1'b0;
      accepted_r    <= 1'b0;
      rank_cnt_r    <= '0;
    end else begin
      case (state_r)
        ST_JUDGE: begin
          accepted_r <= pass;
          if (pass) begin
            held_r        <= held_nxt;
            cur_rtt_r     <= rtt[RTT_W-1:0];
            cur_quality_r <= score_sum[QUAL_W:1];
            cur_sync_r    <= 32'(held_nxt) >= SYNC_MIN;
          end
        end
        ST_LOAD: begin
          rank_cnt_r <= '0;
        end
        ST_RANK: begin
          rank_cnt_r <= rank_cnt_r + CNT_W'(1);
        end
        ST_SEL: begin
          cur_offset_r <= median;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_free) begin
      out_accepted_r <= accepted_r;
      out_offset_r   <= cur_offset_r;
      out_rtt_r      <= cur_rtt_r;
      out_quality_r  <= cur_quality_r;
      out_synced_r   <= cur_sync_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_accepted_r;
  assign out_filtered_offset = out_offset_r;
  assign out_last_round_trip = out_rtt_r;
  assign out_sync_quality    = out_quality_r;
  assign out_synced          = out_synced_r;

endmodule

FILE: sv/cme_checker.sv
// Port-level checks on the clock offset median estimator, bound to the top level.
module cme_checker
  import cme_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_accepted,
  input logic [OFS_W-1:0]  out_filtered_offset,
  input logic [RTT_W-1:0]  out_last_round_trip,
  input logic [QUAL_W-1:0] out_sync_quality,
  input logic              out_synced
);

  localparam logic [QUAL_W-1:0] SYNC_QUAL_MIN =
    QUAL_W'((((SYNC_MIN * 100) / WINDOW_SIZE) + 10) / 2);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered_offset) &&
                              $stable(out_sync_quality) && $stable(out_accepted) &&
                              $stable(out_last_round_trip) && $stable(out_synced))
    else $error("stalled result changed");

  // One exchange is in work at a time, so requests are never taken back to back.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken back to back");

  a_quality_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sync_quality <= 7'd100)
    else $error("quality above 100 percent");

  // Synced needs enough samples, which bounds the quality from below.
  a_synced_quality: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_synced |-> out_sync_quality >= SYNC_QUAL_MIN)
    else $error("synced with too low a quality");

endmodule

bind clock_offset_median_estimator cme_checker u_cme_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_accepted        (out_accepted),
  .out_filtered_offset (out_filtered_offset),
  .out_last_round_trip (out_last_round_trip),
  .out_sync_quality    (out_sync_quality),
  .out_synced          (out_synced)
);
